// ===== rtl/qpd_pkg.sv =====
package qpd_pkg;

    localparam logic [7:0] EQ_CHAR = 8'h3D;
    localparam logic [7:0] CR_CHAR = 8'h0D;
    localparam logic [7:0] LF_CHAR = 8'h0A;

    localparam int RUN_LEN       = 4;
    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last_of_run;
        logic       end_of_message;
    } t_out;

    typedef struct packed {
        t_out [RUN_LEN-1:0] res;
    } t_run;

    function automatic logic hex_ok(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c <= 8'h39) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

// ===== rtl/qpd_front.sv =====
module qpd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  qpd_pkg::t_in  i_in_beat,
    input  logic          i_full,
    output logic          o_push,
    output qpd_pkg::t_run o_run
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_EQ,
        PH_HELD
    } t_phase;

    t_phase        r_phase;
    t_phase        n_phase;
    logic [7:0]    r_held;
    logic [7:0]    n_held;
    logic [2:0]    cnt;
    logic [1:0]    last_idx;
    logic [7:0]    c;
    logic          accept;
    qpd_pkg::t_run run;

    function automatic qpd_pkg::t_out mk(input logic [7:0] b, input logic has,
                                         input logic eom);
        qpd_pkg::t_out r;
        r.out_byte       = b;
        r.has_byte       = has;
        r.last_of_run    = 1'b0;
        r.end_of_message = eom;
        return r;
    endfunction

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        run      = '0;
        cnt      = 3'd0;
        last_idx = 2'd0;
        c        = i_in_beat.data_byte;
        unique case (r_phase)
            PH_EQ: begin
                if (c == qpd_pkg::LF_CHAR) begin
                    n_phase = PH_IDLE;
                end else if ((c == qpd_pkg::CR_CHAR) || qpd_pkg::hex_ok(c)) begin
                    n_held  = c;
                    n_phase = PH_HELD;
                end else begin
                    run.res[cnt[1:0]] = mk(qpd_pkg::EQ_CHAR, 1'b1, 1'b0);
                    cnt = cnt + 3'd1;
                    if (c == qpd_pkg::EQ_CHAR) begin
                        n_phase = PH_EQ;
                    end else begin
                        run.res[cnt[1:0]] = mk(c, 1'b1, 1'b0);
                        cnt = cnt + 3'd1;
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_HELD: begin
                if ((r_held == qpd_pkg::CR_CHAR) && (c == qpd_pkg::LF_CHAR)) begin
                    n_phase = PH_IDLE;
                end else if (qpd_pkg::hex_ok(r_held) && qpd_pkg::hex_ok(c)) begin
                    run.res[cnt[1:0]] = mk({qpd_pkg::hex_val(r_held),
                                            qpd_pkg::hex_val(c)}, 1'b1, 1'b0);
                    cnt = cnt + 3'd1;
                    n_phase = PH_IDLE;
                end else begin
                    run.res[cnt[1:0]] = mk(qpd_pkg::EQ_CHAR, 1'b1, 1'b0);
                    cnt = cnt + 3'd1;
                    run.res[cnt[1:0]] = mk(r_held, 1'b1, 1'b0);
                    cnt = cnt + 3'd1;
                    if (c == qpd_pkg::EQ_CHAR) begin
                        n_phase = PH_EQ;
                    end else begin
                        run.res[cnt[1:0]] = mk(c, 1'b1, 1'b0);
                        cnt = cnt + 3'd1;
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                if (c == qpd_pkg::EQ_CHAR) begin
                    n_phase = PH_EQ;
                end else begin
                    run.res[cnt[1:0]] = mk(c, 1'b1, 1'b0);
                    cnt = cnt + 3'd1;
                    n_phase = PH_IDLE;
                end
            end
        endcase
        if (i_in_beat.message_end) begin
            if ((n_phase == PH_EQ) || (n_phase == PH_HELD)) begin
                run.res[cnt[1:0]] = mk(qpd_pkg::EQ_CHAR, 1'b1, 1'b0);
                cnt = cnt + 3'd1;
            end
            if (n_phase == PH_HELD) begin
                run.res[cnt[1:0]] = mk(n_held, 1'b1, 1'b0);
                cnt = cnt + 3'd1;
            end
            n_phase = PH_IDLE;
            n_held  = 8'h00;
            run.res[cnt[1:0]] = mk(8'h00, 1'b0, 1'b1);
            cnt = cnt + 3'd1;
        end
        if (cnt != 3'd0) begin
            last_idx = 2'(cnt - 3'd1);
            run.res[last_idx].last_of_run = 1'b1;
        end
    end

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && (cnt != 3'd0);
    assign o_run      = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'h00;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

// ===== rtl/qpd_queue.sv =====
module qpd_queue #(
    parameter int Depth = qpd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qpd_pkg::t_run i_run,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_valid,
    output qpd_pkg::t_run o_head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    qpd_pkg::t_run r_mem [Depth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;
    logic            do_pop;

    function automatic logic [PtrW-1:0] wrap(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    assign o_full       = (r_cnt == CntW'(Depth));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= wrap(r_wr);
            end
            if (do_pop) begin
                r_rd <= wrap(r_rd);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

endmodule

// ===== rtl/qpd_back.sv =====
module qpd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  qpd_pkg::t_run i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output qpd_pkg::t_out o_out_beat
);

    logic [1:0]    r_idx;
    logic          r_out_valid;
    qpd_pkg::t_out r_out;
    qpd_pkg::t_out cur;
    logic          emit;

    assign cur   = i_head.res[r_idx];
    assign emit  = i_head_valid && (!r_out_valid || i_out_ready);
    assign o_pop = emit && cur.last_of_run;

    // advance through the run one beat at a time, drop the entry after its last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
            r_idx       <= cur.last_of_run ? 2'd0 : r_idx + 2'd1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= cur;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

// ===== rtl/quoted_printable_decoder_unit.sv =====
// Path: the first result of an accepted input beat is written into the run queue,
// then into the output register, before it can be taken.
// Throughput: one input beat per cycle while each yields at most one result and the
// output is taken; an input that yields several results sends them out one at a
// time, and the input stalls while the run queue between front and back is full.
// Reset (i_rst_n low, synchronous): decode phase idle, nothing held, queue
// and output register empty.
module quoted_printable_decoder_unit #(
    parameter int QueueDepth = qpd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  qpd_pkg::t_in  i_in_beat,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output qpd_pkg::t_out o_out_beat
);

    logic          full;
    logic          push;
    logic          pop;
    logic          head_valid;
    qpd_pkg::t_run run;
    qpd_pkg::t_run head;

    qpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .i_full     (full),
        .o_push     (push),
        .o_run      (run)
    );

    qpd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_run        (run),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    qpd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_beat   (o_out_beat)
    );

endmodule
